### rtl/sha256_pkg.sv
// SHA-256 stream hasher: shared types, round constants and initial hash words.
// No dependencies; imported by sha256_core and sha256_stream_hasher.
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last;
   } sha256_req_type;

   typedef struct packed {
      logic [63:0] digest_part;
      logic        digest_last;
   } sha256_rsp_type;

   // Commands from the sequencer to the compression core
   typedef struct packed {
      logic       init;
      logic       push;
      logic [7:0] push_byte;
      logic       start;
   } sha256_cmd_type;

   localparam logic [7:0] PAD_BYTE  = 8'h80;
   localparam logic [5:0] LEN_POS   = 6'd56;
   localparam logic [5:0] FILL_LAST = 6'd63;
   localparam logic [2:0] OUT_BEATS = 3'd4;

   localparam logic [31:0] START_WORDS [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

endpackage

`default_nettype wire

### rtl/sha256_core.sv
// SHA-256 compression core: 512-bit block shift register doubling as the
// message schedule, one shared round unit, chaining value. Uses sha256_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sha256_core
   import sha256_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire sha256_cmd_type cmd,
   output logic                busy,
   output logic [255:0]        digest
);

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_ROUND,
      CS_ADD
   } core_state_type;

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
   endfunction

   core_state_type state_ff;
   logic [5:0]     round_ff;
   logic [31:0]    h_ff [8];
   logic [31:0]    wv_ff [8];
   logic [511:0]   blk_ff;

   logic [31:0]    w_new;
   logic [31:0]    t1;
   logic [31:0]    t2;

   assign busy = (state_ff != CS_IDLE);

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         digest[255 - 32 * i -: 32] = h_ff[i];
      end
   end

   // schedule word 0 sits at the top of the block register
   assign w_new = blk_ff[511:480] + small_sigma0(blk_ff[479:448])
                + blk_ff[223:192] + small_sigma1(blk_ff[63:32]);

   assign t1 = wv_ff[7] + big_sigma1(wv_ff[4])
             + ((wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]))
             + ROUND_K[round_ff] + blk_ff[511:480];
   assign t2 = big_sigma0(wv_ff[0])
             + ((wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         round_ff <= '0;
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= START_WORDS[i];
         end
      end else begin
         case (state_ff)
            CS_IDLE: begin
               if (cmd.init) begin
                  for (int i = 0; i < 8; i++) begin
                     h_ff[i] <= START_WORDS[i];
                  end
               end
               if (cmd.start) begin
                  round_ff <= '0;
                  state_ff <= CS_ROUND;
               end
            end
            CS_ROUND: begin
               round_ff <= round_ff + 6'd1;
               if (round_ff == FILL_LAST) begin
                  state_ff <= CS_ADD;
               end
            end
            CS_ADD: begin
               for (int i = 0; i < 8; i++) begin
                  h_ff[i] <= h_ff[i] + wv_ff[i];
               end
               state_ff <= CS_IDLE;
            end
            default: begin
               state_ff <= CS_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         blk_ff <= {blk_ff[503:0], cmd.push_byte};
      end else if (state_ff == CS_ROUND) begin
         blk_ff <= {blk_ff[479:0], w_new};
      end
      if (cmd.start) begin
         for (int i = 0; i < 8; i++) begin
            wv_ff[i] <= h_ff[i];
         end
      end else if (state_ff == CS_ROUND) begin
         wv_ff[0] <= t1 + t2;
         wv_ff[1] <= wv_ff[0];
         wv_ff[2] <= wv_ff[1];
         wv_ff[3] <= wv_ff[2];
         wv_ff[4] <= wv_ff[3] + t1;
         wv_ff[5] <= wv_ff[4];
         wv_ff[6] <= wv_ff[5];
         wv_ff[7] <= wv_ff[6];
      end
   end

endmodule

`default_nettype wire

### rtl/sha256_stream_hasher.sv
// SHA-256 stream hasher top level: byte intake, padding sequencer, digest output.
// Depends on sha256_pkg and sha256_core.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_ready   sha256_req_type: data_byte, byte_valid, last
//   rsp      out  rsp_valid/rsp_ready   sha256_rsp_type: digest_part, digest_last
//
// A beat that fills the 64-byte block starts a compression (the 64 rounds of the single
// round unit, then the chaining add), and intake waits until the core hands back.
// A last beat adds the padding bytes (9 to 72), one or two compressions and the load
// of the digest register.
// The four digest beats drain from their own register while the next message is taken
// in; a later last beat waits in the load step until they are gone. Reset is synchronous.
`timescale 1ns / 1ps
`default_nettype none

module sha256_stream_hasher
   import sha256_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire sha256_req_type req_data,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output sha256_rsp_type      rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMP,
      ST_PAD,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PS_MARK,
      PS_ZERO,
      PS_LEN
   } pad_type;

   state_type      state_ff, state_in;
   pad_type        pad_ff, pad_in;
   logic           fin_ff, fin_in;
   logic [5:0]     fill_ff, fill_in;
   logic [60:0]    msg_ff, msg_in;
   logic [2:0]     cnt_ff, cnt_in;
   logic [255:0]   dig_ff, dig_in;

   sha256_cmd_type cmd;
   logic           core_busy;
   logic [255:0]   core_digest;
   logic [5:0]     fill_inc;
   logic [63:0]    len_word;
   logic [7:0]     pad_byte;

   sha256_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .busy   (core_busy),
      .digest (core_digest)
   );

   assign req_ready            = (state_ff == ST_IDLE);
   assign rsp_valid            = (cnt_ff != 3'd0);
   assign rsp_data.digest_part = dig_ff[255:192];
   assign rsp_data.digest_last = (cnt_ff == 3'd1);

   assign fill_inc = fill_ff + 6'd1;
   // length bytes go out big-endian as fill runs from 56 to 63
   assign len_word = {msg_ff, 3'b000} << {fill_ff[2:0], 3'b000};

   always_comb begin
      case (pad_ff)
         PS_MARK: pad_byte = PAD_BYTE;
         PS_LEN:  pad_byte = len_word[63:56];
         default: pad_byte = 8'h00;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      pad_in   = pad_ff;
      fin_in   = fin_ff;
      fill_in  = fill_ff;
      msg_in   = msg_ff;
      cnt_in   = cnt_ff;
      dig_in   = dig_ff;
      cmd      = '0;

      if (rsp_valid && rsp_ready) begin
         dig_in = {dig_ff[191:0], 64'd0};
         cnt_in = cnt_ff - 3'd1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               fin_in = req_data.last;
               pad_in = PS_MARK;
               if (req_data.byte_valid) begin
                  cmd.push      = 1'b1;
                  cmd.push_byte = req_data.data_byte;
                  fill_in       = fill_inc;
                  msg_in        = msg_ff + 61'd1;
                  if (fill_ff == FILL_LAST) begin
                     cmd.start = 1'b1;
                     state_in  = ST_COMP;
                  end else if (req_data.last) begin
                     state_in = ST_PAD;
                  end
               end else if (req_data.last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmd.push      = 1'b1;
            cmd.push_byte = pad_byte;
            fill_in       = fill_inc;
            if (pad_ff == PS_LEN || fill_inc == LEN_POS) begin
               pad_in = PS_LEN;
            end else begin
               pad_in = PS_ZERO;
            end
            if (fill_ff == FILL_LAST) begin
               cmd.start = 1'b1;
               state_in  = ST_COMP;
            end
         end
         ST_COMP: begin
            if (!core_busy) begin
               if (!fin_ff) begin
                  state_in = ST_IDLE;
               end else if (pad_ff == PS_LEN) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_DONE: begin
            if (cnt_ff == 3'd0) begin
               dig_in   = core_digest;
               cnt_in   = OUT_BEATS;
               cmd.init = 1'b1;
               msg_in   = '0;
               fill_in  = '0;
               fin_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pad_ff   <= PS_MARK;
         fin_ff   <= 1'b0;
         fill_ff  <= '0;
         msg_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pad_ff   <= pad_in;
         fin_ff   <= fin_in;
         fill_ff  <= fill_in;
         msg_ff   <= msg_in;
         cnt_ff   <= cnt_in;
      end
      dig_ff <= dig_in;
   end

endmodule

`default_nettype wire

### dv/sha256_stream_hasher_tb.sv
// Self-checking bench for sha256_stream_hasher: byte beats in, 64-bit digest beats out.
// A directed table and random messages are hashed in step by a behavioural SHA-256
// held here; depends on sha256_pkg and the RTL only.
`timescale 1ns / 1ps

module sha256_stream_hasher_tb
   import sha256_pkg::*;
();

   localparam int CYCLE_LIMIT  = 2000000;
   localparam int RANDOM_ITEMS = 300;
   localparam int HOLD_OFF     = 1500;
   localparam int SETTLE       = 300;

   localparam logic [255:0] EMPTY_DIGEST =
      256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
   localparam logic [255:0] ABC_DIGEST =
      256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

   typedef struct packed {
      logic [7:0]   data_byte;
      logic         byte_valid;
      logic         last;
      logic         typed;
      logic [255:0] digest;
   } stim_row_type;

   // typed digests only where obvious; the rest go through the local hash
   localparam stim_row_type DIRECTED [13] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
      '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
      '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
      '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
      '{8'ha5, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
      '{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
      '{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},
      '{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
      '{8'h5a, 1'b0, 1'b1, 1'b0, 256'h0},
      '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
      '{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 256'h0},
      '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}};

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_ready;
   sha256_req_type req_data = '0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   sha256_rsp_type rsp_data;

   sha256_rsp_type pending_digest [$];
   int             mismatches = 0;
   int             cycle_count = 0;
   int             beats_seen = 0;

   logic [31:0]    hash_words [8];
   logic [7:0]     block_bytes [64];
   logic [5:0]     block_fill;
   logic [60:0]    msg_len;

   sha256_stream_hasher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sha256_stream_hasher regression: fail");
         $finish;
      end
   end

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void restart_hash();
      for (int i = 0; i < 8; i++) hash_words[i] = START_WORDS[i];
      block_fill = '0;
      msg_len = '0;
   endfunction

   function automatic void fold_block();
      logic [31:0] w [64];
      logic [31:0] r [8];
      logic [31:0] s0, s1, t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) r[i] = hash_words[i];
      for (int i = 0; i < 64; i++) begin
         t1 = r[7] + (rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25)) +
              ((r[4] & r[5]) ^ (~r[4] & r[6])) + ROUND_K[i] + w[i];
         t2 = (rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22)) +
              ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
         r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
         r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_words[i] = hash_words[i] + r[i];
   endfunction

   function automatic void absorb(input logic [7:0] b);
      block_bytes[block_fill] = b;
      block_fill = block_fill + 6'd1;
      if (block_fill == 6'd0) fold_block();
   endfunction

   // returns 1 with the finished digest when the beat closes a message
   function automatic bit hash_byte_beat(input sha256_req_type item, output logic [255:0] dg);
      logic [63:0] bit_count;
      dg = '0;
      if (item.byte_valid) begin
         absorb(item.data_byte);
         msg_len = msg_len + 61'd1;
      end
      if (!item.last) return 1'b0;
      bit_count = {msg_len, 3'b000};
      absorb(PAD_BYTE);
      while (block_fill != LEN_POS) absorb(8'h00);
      for (int i = 0; i < 8; i++) absorb(bit_count[63 - 8*i -: 8]);
      dg = {hash_words[0], hash_words[1], hash_words[2], hash_words[3],
            hash_words[4], hash_words[5], hash_words[6], hash_words[7]};
      restart_hash();
      return 1'b1;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic deliver(input sha256_req_type item, input bit typed,
                          input logic [255:0] typed_dg, input bit steady);
      logic [255:0] dg;
      int gap;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      if (hash_byte_beat(item, dg)) begin
         if (typed) dg = typed_dg;
         for (int k = 0; k < 4; k++)
            pending_digest.push_back('{digest_part: dg[255 - 64*k -: 64],
                                       digest_last: (k == 3)});
      end
      gap = steady ? 0 : idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin : drain
      int  stall_left;
      bit  steady;
      bit  held;
      sha256_rsp_type want;
      stall_left = 0;
      steady = 1'b0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            beats_seen++;
            if (pending_digest.size() == 0) begin
               $display("%0t: unexpected digest beat %h last %b", $time,
                        rsp_data.digest_part, rsp_data.digest_last);
               mismatches++;
            end else begin
               want = pending_digest.pop_front();
               if (rsp_data.digest_part !== want.digest_part) begin
                  $display("%0t: digest_part expected %h, actual %h", $time,
                           want.digest_part, rsp_data.digest_part);
                  mismatches++;
               end
               if (rsp_data.digest_last !== want.digest_last) begin
                  $display("%0t: digest_last expected %b, actual %b", $time,
                           want.digest_last, rsp_data.digest_last);
                  mismatches++;
               end
            end
            if (rsp_data.digest_last) steady = ($urandom_range(0, 3) == 0);
            stall_left = steady ? 0 : idle_cycles();
            // long hold-off so the block backs up onto its input
            if (!held && beats_seen >= 32) begin
               held = 1'b1;
               stall_left = HOLD_OFF;
            end
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_ready <= (stall_left == 0) && !reset;
      end
   end

   initial begin : stimulus
      sha256_req_type item;
      int  items_counted;
      int  r;
      int  len;
      bit  tail_byte;
      bit  steady;
      items_counted = 0;
      restart_hash();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         item = '{data_byte: DIRECTED[i].data_byte, byte_valid: DIRECTED[i].byte_valid,
                  last: DIRECTED[i].last};
         deliver(item, DIRECTED[i].typed, DIRECTED[i].digest, 1'b0);
      end

      while (items_counted < RANDOM_ITEMS) begin
         steady = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 70) len = $urandom_range(0, 12);
         else if (r < 88) len = $urandom_range(50, 70);
         else if (r < 97) len = $urandom_range(13, 49);
         else len = $urandom_range(100, 140);
         tail_byte = (len > 0) && ($urandom_range(0, 1) == 1);
         for (int n = 0; n < len; n++) begin
            if ($urandom_range(0, 9) == 0) begin
               item = '{data_byte: 8'($urandom), byte_valid: 1'b0, last: 1'b0};
               deliver(item, 1'b0, '0, steady);
               items_counted++;
            end
            item = '{data_byte: 8'($urandom), byte_valid: 1'b1,
                     last: tail_byte && (n == len - 1)};
            deliver(item, 1'b0, '0, steady);
            items_counted++;
         end
         if (!tail_byte) begin
            item = '{data_byte: 8'($urandom), byte_valid: 1'b0, last: 1'b1};
            deliver(item, 1'b0, '0, steady);
            items_counted++;
         end
      end
      req_valid <= 1'b0;

      while (pending_digest.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("sha256_stream_hasher regression: pass");
      end else begin
         $display("sha256_stream_hasher regression: fail");
      end
      $finish;
   end

endmodule
